// ----- rtl/core/eul2rot_pkg.sv -----
// shared widths, constants and helpers for the euler zyx rotation matrix
`default_nettype none
package eul2rot_pkg;

    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned ENTRY_W = 16;
    localparam int unsigned ITERS   = 20;
    localparam int unsigned XW      = 34;   // cordic x/y datapath
    localparam int unsigned ZW      = 34;   // cordic residual angle
    localparam int unsigned TW      = 32;   // sine/cosine q2.30
    localparam int unsigned CW      = 34;   // rounded pair product q30
    localparam int unsigned PW      = 66;   // q60 products and sums
    localparam int unsigned SC_LAT  = ITERS + 2;
    localparam int unsigned MX_LAT  = 4;
    localparam int unsigned LAT     = SC_LAT + MX_LAT;

    localparam logic signed [XW-1:0] CORDIC_K = XW'(652032874);

    typedef logic signed [TW-1:0] trig_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;

    function automatic logic signed [ZW-1:0] atan_turn(input int unsigned idx);
        logic signed [ZW-1:0] r;
        r = '0;
        case (idx)
            0:  r = ZW'(536870912);
            1:  r = ZW'(316933406);
            2:  r = ZW'(167458907);
            3:  r = ZW'(85004756);
            4:  r = ZW'(42667331);
            5:  r = ZW'(21354465);
            6:  r = ZW'(10679838);
            7:  r = ZW'(5340245);
            8:  r = ZW'(2670163);
            9:  r = ZW'(1335087);
            10: r = ZW'(667544);
            11: r = ZW'(333772);
            12: r = ZW'(166886);
            13: r = ZW'(83443);
            14: r = ZW'(41722);
            15: r = ZW'(20861);
            16: r = ZW'(10430);
            17: r = ZW'(5215);
            18: r = ZW'(2608);
            19: r = ZW'(1304);
            default: r = '0;
        endcase
        return r;
    endfunction

    // round q60 to q15 and saturate
    function automatic entry_t finish(input logic signed [PW-1:0] q);
        logic signed [PW-1:0] t;
        t = (q + (PW'(1) <<< 44)) >>> 45;
        if (t > PW'(32767)) begin
            return ENTRY_W'(32767);
        end else if (t < -PW'(32768)) begin
            return ENTRY_W'(-32768);
        end else begin
            return t[ENTRY_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/eul2rot_cordic_stage.sv -----
// one registered cordic rotation step
`default_nettype none
module eul2rot_cordic_stage #(
    parameter int unsigned IDX = 0
) (
    input  wire logic                           aclk,
    input  wire logic                           en,
    input  wire logic                           flip_in,
    input  wire logic signed [eul2rot_pkg::XW-1:0] x_in,
    input  wire logic signed [eul2rot_pkg::XW-1:0] y_in,
    input  wire logic signed [eul2rot_pkg::ZW-1:0] z_in,
    output logic                                flip_out,
    output logic signed [eul2rot_pkg::XW-1:0]   x_out,
    output logic signed [eul2rot_pkg::XW-1:0]   y_out,
    output logic signed [eul2rot_pkg::ZW-1:0]   z_out
);
    logic signed [eul2rot_pkg::XW-1:0] dx, dy, x_next, y_next;
    logic signed [eul2rot_pkg::ZW-1:0] z_next;

    always_comb begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (!z_in[eul2rot_pkg::ZW-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - eul2rot_pkg::atan_turn(IDX);
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + eul2rot_pkg::atan_turn(IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_out    <= x_next;
            y_out    <= y_next;
            z_out    <= z_next;
            flip_out <= flip_in;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/eul2rot_sincos.sv -----
// pipelined sine/cosine: quadrant fold, cordic stages, sign fix
`default_nettype none
module eul2rot_sincos (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [eul2rot_pkg::ANGLE_W-1:0] angle,
    output eul2rot_pkg::trig_t                       sin_out,
    output eul2rot_pkg::trig_t                       cos_out
);
    localparam int unsigned N = eul2rot_pkg::ITERS;

    logic signed [eul2rot_pkg::XW-1:0] x_reg [0:N];
    logic signed [eul2rot_pkg::XW-1:0] y_reg [0:N];
    logic signed [eul2rot_pkg::ZW-1:0] z_reg [0:N];
    logic                              flip_reg [0:N];

    logic signed [eul2rot_pkg::ANGLE_W:0] v_ext, v_next;
    logic                                 flip_next;

    always_comb begin
        v_ext = (eul2rot_pkg::ANGLE_W+1)'(angle);
        if (v_ext > 17'sd16384) begin
            v_next    = v_ext - 17'sd32768;
            flip_next = 1'b1;
        end else if (v_ext < -17'sd16384) begin
            v_next    = v_ext + 17'sd32768;
            flip_next = 1'b1;
        end else begin
            v_next    = v_ext;
            flip_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= eul2rot_pkg::CORDIC_K;
            y_reg[0]    <= '0;
            z_reg[0]    <= eul2rot_pkg::ZW'(v_next) <<< 16;
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        eul2rot_cordic_stage #(.IDX(i)) u_stage (
            .aclk     (aclk),
            .en       (en),
            .flip_in  (flip_reg[i]),
            .x_in     (x_reg[i]),
            .y_in     (y_reg[i]),
            .z_in     (z_reg[i]),
            .flip_out (flip_reg[i+1]),
            .x_out    (x_reg[i+1]),
            .y_out    (y_reg[i+1]),
            .z_out    (z_reg[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (flip_reg[N]) begin
                cos_out <= eul2rot_pkg::TW'(-x_reg[N]);
                sin_out <= eul2rot_pkg::TW'(-y_reg[N]);
            end else begin
                cos_out <= eul2rot_pkg::TW'(x_reg[N]);
                sin_out <= eul2rot_pkg::TW'(y_reg[N]);
            end
        end
    end

    // residual angle is not needed past the last stage
    logic unused_z;
    assign unused_z = ^z_reg[N];
endmodule
`default_nettype wire

// ----- rtl/core/eul2rot_matrix.sv -----
// four-stage product and sum pipeline that forms the nine entries
`default_nettype none
module eul2rot_matrix (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire eul2rot_pkg::trig_t  sa,
    input  wire eul2rot_pkg::trig_t  ca,
    input  wire eul2rot_pkg::trig_t  sb,
    input  wire eul2rot_pkg::trig_t  cb,
    input  wire eul2rot_pkg::trig_t  sg,
    input  wire eul2rot_pkg::trig_t  cg,
    output eul2rot_pkg::entry_t      r_out [0:8]
);
    localparam int unsigned PW = eul2rot_pkg::PW;
    localparam int unsigned CW = eul2rot_pkg::CW;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [CW-1:0] pair_t;

    eul2rot_pkg::trig_t sa1_reg, ca1_reg, sb1_reg, cb1_reg, sg1_reg, cg1_reg;
    eul2rot_pkg::trig_t sa2_reg, ca2_reg, sb2_reg, cb2_reg, sg2_reg, cg2_reg;
    prod_t cgsb1_reg, sgsb1_reg;
    pair_t cgsb2_reg, sgsb2_reg;
    prod_t p_reg [0:11];
    prod_t nsb_reg;

    function automatic prod_t mul(input logic signed [CW-1:0] a,
                                  input logic signed [CW-1:0] b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: pair products for three-factor terms
            cgsb1_reg <= mul(CW'(cg), CW'(sb));
            sgsb1_reg <= mul(CW'(sg), CW'(sb));
            sa1_reg <= sa; ca1_reg <= ca; sb1_reg <= sb;
            cb1_reg <= cb; sg1_reg <= sg; cg1_reg <= cg;
            // stage 2: round pairs to q30
            cgsb2_reg <= CW'((cgsb1_reg + (prod_t'(1) <<< 29)) >>> 30);
            sgsb2_reg <= CW'((sgsb1_reg + (prod_t'(1) <<< 29)) >>> 30);
            sa2_reg <= sa1_reg; ca2_reg <= ca1_reg; sb2_reg <= sb1_reg;
            cb2_reg <= cb1_reg; sg2_reg <= sg1_reg; cg2_reg <= cg1_reg;
            // stage 3: all remaining products
            p_reg[0]  <= mul(CW'(cg2_reg), CW'(cb2_reg));
            p_reg[1]  <= mul(cgsb2_reg,    CW'(sa2_reg));
            p_reg[2]  <= mul(CW'(sg2_reg), CW'(ca2_reg));
            p_reg[3]  <= mul(CW'(sg2_reg), CW'(sa2_reg));
            p_reg[4]  <= mul(cgsb2_reg,    CW'(ca2_reg));
            p_reg[5]  <= mul(CW'(sg2_reg), CW'(cb2_reg));
            p_reg[6]  <= mul(CW'(cg2_reg), CW'(ca2_reg));
            p_reg[7]  <= mul(sgsb2_reg,    CW'(sa2_reg));
            p_reg[8]  <= mul(sgsb2_reg,    CW'(ca2_reg));
            p_reg[9]  <= mul(CW'(cg2_reg), CW'(sa2_reg));
            p_reg[10] <= mul(CW'(cb2_reg), CW'(sa2_reg));
            p_reg[11] <= mul(CW'(cb2_reg), CW'(ca2_reg));
            nsb_reg   <= -(prod_t'(sb2_reg) <<< 30);
            // stage 4: sums, rounding and saturation
            r_out[0] <= eul2rot_pkg::finish(p_reg[0]);
            r_out[1] <= eul2rot_pkg::finish(p_reg[1] - p_reg[2]);
            r_out[2] <= eul2rot_pkg::finish(p_reg[3] + p_reg[4]);
            r_out[3] <= eul2rot_pkg::finish(p_reg[5]);
            r_out[4] <= eul2rot_pkg::finish(p_reg[6] + p_reg[7]);
            r_out[5] <= eul2rot_pkg::finish(p_reg[8] - p_reg[9]);
            r_out[6] <= eul2rot_pkg::finish(nsb_reg);
            r_out[7] <= eul2rot_pkg::finish(p_reg[10]);
            r_out[8] <= eul2rot_pkg::finish(p_reg[11]);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/euler_angles_to_rotation_matrix.sv -----
// top level: euler zyx angles in, 3x3 rotation matrix out
//
//  channel | dir | payload
//  s_*     | in  | tdata[47:0]   = angle_x, angle_y, angle_z
//  m_*     | out | tdata[143:0]  = r00 r01 r02 r10 r11 r12 r20 r21 r22
//
// pipeline stages: 1 fold, 20 cordic steps, 1 sign fix, 4 product/sum.
// one word per cycle sustained while m_tready does not stall the pipe; the cordic
// steps and the 12 product multipliers each take a new word every enabled cycle.
// aresetn clears only the valid bits; data registers carry no reset.
// a stall on m_tready freezes the whole pipe, so nothing is lost or repeated.
`default_nettype none
module euler_angles_to_rotation_matrix (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // angle_x, angle_y, angle_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata    // r00 r01 r02 r10 r11 r12 r20 r21 r22
);
    localparam int unsigned LAT = eul2rot_pkg::LAT;

    logic [LAT-1:0] vld_reg;
    logic           en;
    eul2rot_pkg::trig_t sa, ca, sb, cb, sg, cg;
    eul2rot_pkg::entry_t r [0:8];

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    eul2rot_sincos u_sc_x (.aclk(aclk), .en(en), .angle(s_tdata[15:0]),
                           .sin_out(sa), .cos_out(ca));
    eul2rot_sincos u_sc_y (.aclk(aclk), .en(en), .angle(s_tdata[31:16]),
                           .sin_out(sb), .cos_out(cb));
    eul2rot_sincos u_sc_z (.aclk(aclk), .en(en), .angle(s_tdata[47:32]),
                           .sin_out(sg), .cos_out(cg));

    eul2rot_matrix u_mx (
        .aclk (aclk), .en (en),
        .sa (sa), .ca (ca), .sb (sb), .cb (cb), .sg (sg), .cg (cg),
        .r_out (r)
    );

    assign m_tdata = {r[8], r[7], r[6], r[5], r[4], r[3], r[2], r[1], r[0]};
endmodule
`default_nettype wire

// ----- rtl/core/eul2rot_checker.sv -----
// port-level checks for the rotation matrix block, bound to the top level
`default_nettype none
module eul2rot_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [143:0] m_tdata
);
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output side");

    a_free_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("empty output blocks input");

    logic unused_sv;
    assign unused_sv = s_tvalid;
endmodule

bind euler_angles_to_rotation_matrix eul2rot_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
